/* hdl/ssc_pkg.sv */
// Shared types, keyword encodings and lookup functions for the SQL statement classifier.
package ssc_pkg;

  // Statement kind codes as they appear on the result stream.
  typedef enum logic [3:0] {
    KIND_UNKNOWN      = 4'd0,
    KIND_SELECT       = 4'd1,
    KIND_INSERT       = 4'd2,
    KIND_UPDATE       = 4'd3,
    KIND_DELETE       = 4'd4,
    KIND_CREATE_TABLE = 4'd5,
    KIND_CREATE_INDEX = 4'd6,
    KIND_ALTER        = 4'd7,
    KIND_DROP_TABLE   = 4'd8,
    KIND_DROP_INDEX   = 4'd9,
    KIND_TRUNCATE     = 4'd10,
    KIND_BEGIN        = 4'd11,
    KIND_COMMIT       = 4'd12,
    KIND_ROLLBACK     = 4'd13,
    KIND_SET          = 4'd14,
    KIND_SHOW         = 4'd15
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_EMPTY       = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_t;

  // Word buffer sizes. A length one past the maximum marks an overlong word.
  localparam logic [3:0] FIRST_MAX   = 4'd8;
  localparam logic [3:0] FIRST_LONG  = 4'd9;
  localparam logic [2:0] SECOND_MAX  = 3'd6;
  localparam logic [2:0] SECOND_LONG = 3'd7;

  // Lower-case keywords, first letter in the upper bytes.
  localparam logic [63:0] KW_SELECT   = 64'h0000_7365_6c65_6374;
  localparam logic [63:0] KW_INSERT   = 64'h0000_696e_7365_7274;
  localparam logic [63:0] KW_UPDATE   = 64'h0000_7570_6461_7465;
  localparam logic [63:0] KW_DELETE   = 64'h0000_6465_6c65_7465;
  localparam logic [63:0] KW_CREATE   = 64'h0000_6372_6561_7465;
  localparam logic [63:0] KW_ALTER    = 64'h0000_0061_6c74_6572;
  localparam logic [63:0] KW_DROP     = 64'h0000_0000_6472_6f70;
  localparam logic [63:0] KW_TRUNCATE = 64'h7472_756e_6361_7465;
  localparam logic [63:0] KW_BEGIN    = 64'h0000_0062_6567_696e;
  localparam logic [63:0] KW_START    = 64'h0000_0073_7461_7274;
  localparam logic [63:0] KW_COMMIT   = 64'h0000_636f_6d6d_6974;
  localparam logic [63:0] KW_ROLLBACK = 64'h726f_6c6c_6261_636b;
  localparam logic [63:0] KW_SET      = 64'h0000_0000_0073_6574;
  localparam logic [63:0] KW_SHOW     = 64'h0000_0000_7368_6f77;
  localparam logic [47:0] KW_INDEX    = 48'h0069_6e64_6578;
  localparam logic [47:0] KW_UNIQUE   = 48'h756e_6971_7565;

  // Map the first word to a base kind; the length must match as well as the letters.
  function automatic kind_t first_kind(logic [63:0] w, logic [3:0] n);
    kind_t k;
    k = KIND_UNKNOWN;
    if      (n == 4'd6 && w == KW_SELECT)   k = KIND_SELECT;
    else if (n == 4'd6 && w == KW_INSERT)   k = KIND_INSERT;
    else if (n == 4'd6 && w == KW_UPDATE)   k = KIND_UPDATE;
    else if (n == 4'd6 && w == KW_DELETE)   k = KIND_DELETE;
    else if (n == 4'd6 && w == KW_CREATE)   k = KIND_CREATE_TABLE;
    else if (n == 4'd5 && w == KW_ALTER)    k = KIND_ALTER;
    else if (n == 4'd4 && w == KW_DROP)     k = KIND_DROP_TABLE;
    else if (n == 4'd8 && w == KW_TRUNCATE) k = KIND_TRUNCATE;
    else if (n == 4'd5 && w == KW_BEGIN)    k = KIND_BEGIN;
    else if (n == 4'd5 && w == KW_START)    k = KIND_BEGIN;
    else if (n == 4'd6 && w == KW_COMMIT)   k = KIND_COMMIT;
    else if (n == 4'd8 && w == KW_ROLLBACK) k = KIND_ROLLBACK;
    else if (n == 4'd3 && w == KW_SET)      k = KIND_SET;
    else if (n == 4'd4 && w == KW_SHOW)     k = KIND_SHOW;
    return k;
  endfunction

  // True when the second word names an index.
  function automatic logic second_is_index(logic [47:0] w, logic [2:0] n);
    return (n == 3'd5 && w == KW_INDEX) || (n == 3'd6 && w == KW_UNIQUE);
  endfunction

endpackage

/* hdl/sql_statement_classifier.sv */
// Top level of the SQL statement classifier: byte stream in, one type result per statement out.
//
// The block takes one byte of SQL text per request on the in_ channel, with in_tlast on the
// final byte, and returns one result per statement on the out_ channel. It accepts a byte in
// every cycle unless the stall below holds: each byte lands in an input register, from which a
// single pass of whitespace/letter decoding, a shift into the word buffers and the keyword
// compare updates the parse state and, for a last byte, loads the result register that drives
// out_tvalid. The only stall is a last byte that finds the previous result still waiting on
// out_tready: it holds in the input register, and in_tready stays low, until that result is
// taken. The leading word is matched case-blind against the statement keywords (start counts
// as begin); after create or drop a second word of index or unique selects the index form.
// All state returns to its idle values after each last byte, so statements are independent.
module sql_statement_classifier
  import ssc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] stmt_kind, [5:4] status, [6] wr_flag, [7] txn_flag
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_GAP    = 3'd2,
    PH_SECOND = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  // Parse state.
  phase_t      phase_r, phase_nxt;
  logic [63:0] first_word_r, first_word_nxt;
  logic [3:0]  first_len_r, first_len_nxt;
  logic [47:0] second_word_r, second_word_nxt;
  logic [2:0]  second_len_r, second_len_nxt;

  // Result register.
  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic       is_space;
  logic       is_letter;
  logic [7:0] folded;
  kind_t      kind;
  status_t    status;
  logic       wr_flag;
  logic       is_trans;

  // A byte leaves the input register unless it would need the busy result register.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // Byte classes; setting bit 5 folds an upper-case letter to lower case.
  assign is_space  = (s1_byte_r == 8'h20) || (s1_byte_r inside {[8'h09:8'h0D]});
  assign is_letter = s1_byte_r inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign folded    = s1_byte_r | 8'h20;

  // Phase and word buffer update for the byte in the input register.
  always_comb begin
    phase_nxt       = phase_r;
    first_word_nxt  = first_word_r;
    first_len_nxt   = first_len_r;
    second_word_nxt = second_word_r;
    second_len_nxt  = second_len_r;
    case (phase_r)
      PH_LEAD, PH_FIRST: begin
        if (is_letter) begin
          phase_nxt = PH_FIRST;
          if (first_len_r < FIRST_MAX) begin
            first_word_nxt = {first_word_r[55:0], folded};
            first_len_nxt  = first_len_r + 4'd1;
          end else begin
            first_len_nxt = FIRST_LONG;
          end
        end else if (is_space) begin
          phase_nxt = (phase_r == PH_LEAD) ? PH_LEAD : PH_GAP;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_GAP, PH_SECOND: begin
        if (is_letter) begin
          phase_nxt = PH_SECOND;
          if (second_len_r < SECOND_MAX) begin
            second_word_nxt = {second_word_r[39:0], folded};
            second_len_nxt  = second_len_r + 3'd1;
          end else begin
            second_len_nxt = SECOND_LONG;
          end
        end else if (is_space && phase_r == PH_GAP) begin
          phase_nxt = PH_GAP;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Classification of the statement as it stands after this byte.
  always_comb begin
    kind = first_kind(first_word_nxt, first_len_nxt);
    if (second_is_index(second_word_nxt, second_len_nxt)) begin
      if (kind == KIND_CREATE_TABLE) kind = KIND_CREATE_INDEX;
      else if (kind == KIND_DROP_TABLE) kind = KIND_DROP_INDEX;
    end
    if (phase_nxt == PH_LEAD) begin
      kind   = KIND_UNKNOWN;
      status = STATUS_EMPTY;
    end else if (kind == KIND_UNKNOWN) begin
      status = STATUS_UNSUPPORTED;
    end else begin
      status = STATUS_OK;
    end
    wr_flag  = kind inside {KIND_INSERT, KIND_UPDATE, KIND_DELETE, KIND_CREATE_TABLE,
                            KIND_ALTER, KIND_DROP_TABLE, KIND_TRUNCATE};
    is_trans = kind inside {KIND_BEGIN, KIND_COMMIT, KIND_ROLLBACK};
  end

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Parse state and result register; a last byte loads the result and returns the parser
  // to the idle values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEAD;
      first_word_r  <= '0;
      first_len_r   <= '0;
      second_word_r <= '0;
      second_len_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (s1_adv && s1_last_r) begin
        phase_r       <= PH_LEAD;
        first_word_r  <= '0;
        first_len_r   <= '0;
        second_word_r <= '0;
        second_len_r  <= '0;
      end else if (s1_adv) begin
        phase_r       <= phase_nxt;
        first_word_r  <= first_word_nxt;
        first_len_r   <= first_len_nxt;
        second_word_r <= second_word_nxt;
        second_len_r  <= second_len_nxt;
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (s1_adv && s1_last_r) begin
      out_data_r <= {is_trans, wr_flag, status, kind};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A finished statement always yields a result and leaves the parser idle.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_valid_r && phase_r == PH_LEAD && first_len_r == 4'd0)
    else $error("last byte did not produce a result or clear the parse state");

  // Letters are only held once the leading whitespace is behind.
  a_len_phase: assert property (@(posedge clk) disable iff (!rst_n)
    first_len_r != 4'd0 |-> phase_r != PH_LEAD)
    else $error("first word held while still skipping leading whitespace");

  // A second word exists only after a first word ended in whitespace.
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    second_len_r != 3'd0 |-> first_len_r != 4'd0)
    else $error("second word gathered without a first word");

  // An empty statement never carries a kind or flags.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[5:4] == STATUS_EMPTY |-> out_data_r[3:0] == KIND_UNKNOWN
      && out_data_r[7:6] == 2'b00)
    else $error("empty statement result carries a kind");

endmodule
